@@ rtl/rpn_stack_evaluator_assert.svh @@
// Assertion macros shared by the rpn_stack_evaluator checker.
// Needs nothing else; included by files that hold concurrent assertions.
`ifndef RPN_STACK_EVALUATOR_ASSERT_SVH
`define RPN_STACK_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

@@ rtl/rse_pkg.sv @@
// Shared constants and types for the RPN stack evaluator.
// No dependencies; used by rpn_stack_evaluator.
package rse_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int WORD_W      = 32;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DIV_CNT_W   = $clog2(WORD_W);

	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SYM  = 11'b000_0000_0010,
		ST_LAST = 11'b000_0000_0100,
		ST_POP1 = 11'b000_0000_1000,
		ST_POP2 = 11'b000_0001_0000,
		ST_EXEC = 11'b000_0010_0000,
		ST_DIV  = 11'b000_0100_0000,
		ST_SIGN = 11'b000_1000_0000,
		ST_PUSH = 11'b001_0000_0000,
		ST_TOP  = 11'b010_0000_0000,
		ST_EMIT = 11'b100_0000_0000
	} state_t;

endpackage

@@ rtl/rpn_stack_evaluator.sv @@
// RPN (postfix) expression evaluator: sequencer, operand stack memory and shared ALU.
// Depends on rse_pkg.
//
// Takes one ASCII character per transfer on the slave side, s_tlast marking the final
// character of an expression, and returns one result per expression on the master side:
// m_tdata is the signed 32-bit top of stack (0 on error or empty stack), m_tuser is the
// sticky divide-by-zero flag. s_tready is high only while the sequencer is idle. + and *
// make two registered stack reads, an ALU step and a push; a held minus that turns out
// to be a subtraction is applied before the character after it, or at the end if the
// minus is last; / runs the 32-step restoring divider in the shared ALU unless the
// divisor is zero. The last character then reads the top and loads the output register,
// after any wait for the previous result to be taken; the register holds the result
// until it is taken while the next expression already streams in. The operand stack is
// 64 words of 32 bits; pushes onto a full stack are dropped and pops from an empty one
// give 0.
module rpn_stack_evaluator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rse_pkg::SYM_W-1:0]      s_tdata,   // [7:0] symbol
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rse_pkg::WORD_W-1:0]     m_tdata,   // [31:0] value
	output logic                           m_tuser    // [0] divide_by_zero
);

	localparam int W = rse_pkg::WORD_W;

	rse_pkg::state_t                  state_q;
	rse_pkg::state_t                  ret_q;
	rse_pkg::op_t                     op_q;
	logic [rse_pkg::SYM_W-1:0]        sym_q;
	logic                             last_q;
	logic [rse_pkg::CNT_W-1:0]        count_q;
	logic [W-1:0]                     acc_q;
	logic                             in_num_q;
	logic                             neg_q;
	logic                             pend_q;
	logic                             err_q;
	logic                             rz_q;
	logic [W-1:0]                     right_q;
	logic [W-1:0]                     res_q;
	logic [W-1:0]                     rem_q;
	logic [W-1:0]                     quo_q;
	logic [W-1:0]                     dvs_q;
	logic                             qneg_q;
	logic [rse_pkg::DIV_CNT_W-1:0]    dcnt_q;
	logic [W-1:0]                     rd_q;

	logic [W-1:0]                     mem_q [rse_pkg::STACK_DEPTH];

	logic                             is_digit;
	logic [3:0]                       dig;
	logic [W-1:0]                     dig_ext;
	logic [W-1:0]                     acc_x10;
	logic [W-1:0]                     num_val;
	logic                             not_full;
	logic                             push_num;
	logic [W-1:0]                     left;
	logic [W:0]                       trial;
	logic                             ge;
	logic                             we;
	logic [W-1:0]                     wdata;
	logic                             re;
	logic [rse_pkg::ADDR_W-1:0]       waddr;
	logic [rse_pkg::ADDR_W-1:0]       raddr;
	logic [rse_pkg::CNT_W-1:0]        cnt_m1;

	assign s_tready = (state_q == rse_pkg::ST_IDLE);

	always_comb begin
		is_digit = sym_q inside {[rse_pkg::CH_ZERO:rse_pkg::CH_NINE]};
		dig      = 4'(sym_q - rse_pkg::CH_ZERO);
		dig_ext  = W'(dig);
		acc_x10  = (acc_q << 3) + (acc_q << 1) + dig_ext;
		num_val  = neg_q ? (W'(0) - acc_q) : acc_q;
		not_full = (count_q < rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH));
		push_num = in_num_q && not_full;
		left     = rz_q ? '0 : rd_q;
		trial    = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};
		ge       = !trial[W];
		cnt_m1   = count_q - rse_pkg::CNT_W'(1);
		raddr    = cnt_m1[rse_pkg::ADDR_W-1:0];
		waddr    = count_q[rse_pkg::ADDR_W-1:0];
		re       = (count_q != '0) && ((state_q == rse_pkg::ST_POP1) ||
			(state_q == rse_pkg::ST_POP2) || (state_q == rse_pkg::ST_TOP));
		we       = 1'b0;
		wdata    = num_val;
		case (state_q)
			rse_pkg::ST_SYM: begin
				we = !pend_q && !is_digit && push_num;
			end
			rse_pkg::ST_LAST: begin
				we = last_q && push_num;
			end
			rse_pkg::ST_PUSH: begin
				we    = not_full;
				wdata = res_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// operand stack: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rse_pkg::ST_IDLE;
			ret_q    <= rse_pkg::ST_IDLE;
			op_q     <= rse_pkg::OP_ADD;
			sym_q    <= '0;
			last_q   <= 1'b0;
			count_q  <= '0;
			acc_q    <= '0;
			in_num_q <= 1'b0;
			neg_q    <= 1'b0;
			pend_q   <= 1'b0;
			err_q    <= 1'b0;
			rz_q     <= 1'b0;
			right_q  <= '0;
			res_q    <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			dvs_q    <= '0;
			qneg_q   <= 1'b0;
			dcnt_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tuser  <= 1'b0;
		end else begin
			// in ST_EMIT the output register is reloaded instead
			if (m_tvalid && m_tready && (state_q != rse_pkg::ST_EMIT)) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				rse_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						sym_q   <= s_tdata;
						last_q  <= s_tlast;
						state_q <= rse_pkg::ST_SYM;
					end
				end
				rse_pkg::ST_SYM: begin
					if (pend_q) begin
						pend_q <= 1'b0;
						if (is_digit) begin
							in_num_q <= 1'b1;
							neg_q    <= 1'b1;
							acc_q    <= dig_ext;
							state_q  <= rse_pkg::ST_LAST;
						end else begin
							// held minus was subtraction; revisit this symbol after it
							op_q    <= rse_pkg::OP_SUB;
							ret_q   <= rse_pkg::ST_SYM;
							state_q <= rse_pkg::ST_POP1;
						end
					end else if (is_digit) begin
						acc_q    <= in_num_q ? acc_x10 : dig_ext;
						neg_q    <= in_num_q && neg_q;
						in_num_q <= 1'b1;
						state_q  <= rse_pkg::ST_LAST;
					end else begin
						if (push_num) begin
							count_q <= count_q + rse_pkg::CNT_W'(1);
						end
						in_num_q <= 1'b0;
						neg_q    <= 1'b0;
						acc_q    <= '0;
						ret_q    <= rse_pkg::ST_LAST;
						case (sym_q)
							rse_pkg::CH_PLUS: begin
								op_q    <= rse_pkg::OP_ADD;
								state_q <= rse_pkg::ST_POP1;
							end
							rse_pkg::CH_STAR: begin
								op_q    <= rse_pkg::OP_MUL;
								state_q <= rse_pkg::ST_POP1;
							end
							rse_pkg::CH_SLASH: begin
								op_q    <= rse_pkg::OP_DIV;
								state_q <= rse_pkg::ST_POP1;
							end
							rse_pkg::CH_MINUS: begin
								pend_q  <= 1'b1;
								state_q <= rse_pkg::ST_LAST;
							end
							default: begin
								state_q <= rse_pkg::ST_LAST;
							end
						endcase
					end
				end
				rse_pkg::ST_LAST: begin
					if (!last_q) begin
						state_q <= rse_pkg::ST_IDLE;
					end else begin
						if (push_num) begin
							count_q <= count_q + rse_pkg::CNT_W'(1);
						end
						in_num_q <= 1'b0;
						neg_q    <= 1'b0;
						acc_q    <= '0;
						if (pend_q) begin
							pend_q  <= 1'b0;
							op_q    <= rse_pkg::OP_SUB;
							ret_q   <= rse_pkg::ST_TOP;
							state_q <= rse_pkg::ST_POP1;
						end else begin
							state_q <= rse_pkg::ST_TOP;
						end
					end
				end
				rse_pkg::ST_POP1: begin
					rz_q <= (count_q == '0);
					if (count_q != '0) begin
						count_q <= cnt_m1;
					end
					state_q <= rse_pkg::ST_POP2;
				end
				rse_pkg::ST_POP2: begin
					right_q <= left;
					rz_q    <= (count_q == '0);
					if (count_q != '0) begin
						count_q <= cnt_m1;
					end
					state_q <= rse_pkg::ST_EXEC;
				end
				rse_pkg::ST_EXEC: begin
					state_q <= rse_pkg::ST_PUSH;
					case (op_q)
						rse_pkg::OP_ADD: begin
							res_q <= left + right_q;
						end
						rse_pkg::OP_SUB: begin
							res_q <= left - right_q;
						end
						rse_pkg::OP_MUL: begin
							res_q <= W'(left * right_q);
						end
						default: begin
							if (right_q == '0) begin
								err_q <= 1'b1;
								res_q <= '0;
							end else begin
								quo_q   <= left[W-1] ? (W'(0) - left) : left;
								dvs_q   <= right_q[W-1] ? (W'(0) - right_q) : right_q;
								rem_q   <= '0;
								qneg_q  <= left[W-1] ^ right_q[W-1];
								dcnt_q  <= '0;
								state_q <= rse_pkg::ST_DIV;
							end
						end
					endcase
				end
				rse_pkg::ST_DIV: begin
					rem_q  <= ge ? trial[W-1:0] : {rem_q[W-2:0], quo_q[W-1]};
					quo_q  <= {quo_q[W-2:0], ge};
					dcnt_q <= dcnt_q + rse_pkg::DIV_CNT_W'(1);
					if (dcnt_q == rse_pkg::DIV_CNT_W'(W - 1)) begin
						state_q <= rse_pkg::ST_SIGN;
					end
				end
				rse_pkg::ST_SIGN: begin
					res_q   <= qneg_q ? (W'(0) - quo_q) : quo_q;
					state_q <= rse_pkg::ST_PUSH;
				end
				rse_pkg::ST_PUSH: begin
					if (not_full) begin
						count_q <= count_q + rse_pkg::CNT_W'(1);
					end
					state_q <= ret_q;
				end
				rse_pkg::ST_TOP: begin
					rz_q    <= (count_q == '0);
					state_q <= rse_pkg::ST_EMIT;
				end
				rse_pkg::ST_EMIT: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= (err_q || rz_q) ? '0 : rd_q;
						m_tuser  <= err_q;
						m_tvalid <= 1'b1;
						count_q  <= '0;
						acc_q    <= '0;
						in_num_q <= 1'b0;
						neg_q    <= 1'b0;
						pend_q   <= 1'b0;
						err_q    <= 1'b0;
						state_q  <= rse_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= rse_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/rse_checker.sv @@
// Port-level checker for rpn_stack_evaluator, bound to the top level.
// Depends on rpn_stack_evaluator_assert.svh.
`include "rpn_stack_evaluator_assert.svh"

module rse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// a transfer in starts the sequencer, which then stalls the input
	`RSE_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready, "input ready right after a transfer")

	// an error result always carries a zero value
	`RSE_ASSERT_IMPL(a_err_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == 32'd0, "nonzero value with divide-by-zero flag")

	// a new result never appears in the cycle after an input transfer
	`RSE_ASSERT_NEXT(a_no_fast_out, clk, arst_n, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result too soon after input")

	// stalled result holds
	`RSE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);

@@ tb/sv/tb_rpn_stack_evaluator.sv @@
// Self-checking testbench for rpn_stack_evaluator: a directed table, then random postfix
// expressions under several idle/stall mixes, checked against an in-bench evaluator.
// Depends on rse_pkg and the rpn_stack_evaluator RTL.
module tb_rpn_stack_evaluator;
	import rse_pkg::*;

	localparam int PHASE_ITEMS    = 450;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 64;

	typedef struct packed {
		logic [SYM_W-1:0]  sym;
		logic              last;
		logic              typed;
		logic [WORD_W-1:0] tval;
		logic              tdz;
	} sym_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              dz;
	} result_t;

	localparam logic [SYM_W-1:0] OP_CHARS [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	// sym, last, typed, value, divide_by_zero
	localparam sym_item_t DIRECTED_ROWS [24] = '{
		'{" ",      1'b1, 1'b1, 32'd0,         1'b0},
		'{"9",      1'b1, 1'b1, 32'd9,         1'b0},
		'{"7",      1'b0, 1'b0, 32'd0,         1'b0},
		'{" ",      1'b0, 1'b0, 32'd0,         1'b0},
		'{"0",      1'b0, 1'b0, 32'd0,         1'b0},
		'{CH_SLASH, 1'b1, 1'b1, 32'd0,         1'b1},
		'{CH_MINUS, 1'b0, 1'b0, 32'd0,         1'b0},
		'{"5",      1'b1, 1'b1, 32'hFFFF_FFFB, 1'b0},
		'{"8",      1'b0, 1'b0, 32'd0,         1'b0},
		'{" ",      1'b0, 1'b0, 32'd0,         1'b0},
		'{"3",      1'b0, 1'b0, 32'd0,         1'b0},
		'{CH_MINUS, 1'b1, 1'b1, 32'd5,         1'b0},
		'{"6",      1'b0, 1'b0, 32'd0,         1'b0},
		'{" ",      1'b0, 1'b0, 32'd0,         1'b0},
		'{"7",      1'b0, 1'b0, 32'd0,         1'b0},
		'{CH_STAR,  1'b1, 1'b1, 32'd42,        1'b0},
		'{CH_PLUS,  1'b1, 1'b1, 32'd0,         1'b0},
		'{8'hFF,    1'b0, 1'b0, 32'd0,         1'b0},
		'{"3",      1'b1, 1'b1, 32'd3,         1'b0},
		'{CH_MINUS, 1'b0, 1'b0, 32'd0,         1'b0},
		'{"7",      1'b0, 1'b0, 32'd0,         1'b0},
		'{" ",      1'b0, 1'b0, 32'd0,         1'b0},
		'{"2",      1'b0, 1'b0, 32'd0,         1'b0},
		'{CH_SLASH, 1'b1, 1'b0, 32'd0,         1'b0}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [SYM_W-1:0]  s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [WORD_W-1:0] m_tdata;
	logic              m_tuser;

	logic              drv_typed = 1'b0;
	logic [WORD_W-1:0] drv_tval = '0;
	logic              drv_tdz = 1'b0;

	int          src_idle_pct = 0;
	int          sink_stall_pct = 0;
	bit          hold_req = 1'b0;
	int          mismatches = 0;
	int          stall_cycles = 0;
	sym_item_t   stim_q[$];
	result_t     exp_results[$];

	// evaluator state
	logic [WORD_W-1:0] opnd_stk [STACK_DEPTH];
	int unsigned       opnd_cnt = 0;
	logic [WORD_W-1:0] num_acc = '0;
	bit                num_active = 1'b0;
	bit                num_neg = 1'b0;
	bit                minus_held = 1'b0;
	bit                div0_seen = 1'b0;

	rpn_stack_evaluator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_eval();
		opnd_cnt = 0;
		num_acc = '0;
		num_active = 1'b0;
		num_neg = 1'b0;
		minus_held = 1'b0;
		div0_seen = 1'b0;
	endfunction

	function automatic void stk_push(input logic [WORD_W-1:0] v);
		if (opnd_cnt < STACK_DEPTH) begin
			opnd_stk[opnd_cnt] = v;
			opnd_cnt++;
		end
	endfunction

	function automatic logic [WORD_W-1:0] stk_pop();
		if (opnd_cnt == 0)
			return '0;
		opnd_cnt--;
		return opnd_stk[opnd_cnt];
	endfunction

	// truncates toward zero; most negative / -1 wraps
	function automatic logic [WORD_W-1:0] quot_trunc(input logic [WORD_W-1:0] a,
			input logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] ma, mb, q;
		ma = a[WORD_W-1] ? -a : a;
		mb = b[WORD_W-1] ? -b : b;
		q = ma / mb;
		return (a[WORD_W-1] != b[WORD_W-1]) ? -q : q;
	endfunction

	function automatic void apply_op(input op_t op);
		logic [WORD_W-1:0] rhs, lhs, r;
		rhs = stk_pop();
		lhs = stk_pop();
		r = '0;
		case (op)
			OP_ADD: r = lhs + rhs;
			OP_SUB: r = lhs - rhs;
			OP_MUL: r = lhs * rhs;
			OP_DIV: begin
				if (rhs == '0)
					div0_seen = 1'b1;
				else
					r = quot_trunc(lhs, rhs);
			end
			default: ;
		endcase
		stk_push(r);
	endfunction

	function automatic void close_number();
		if (num_active)
			stk_push(num_neg ? -num_acc : num_acc);
		num_active = 1'b0;
		num_neg = 1'b0;
		num_acc = '0;
	endfunction

	function automatic void take_char(input logic [SYM_W-1:0] c);
		bit dig;
		logic [WORD_W-1:0] d;
		dig = (c >= CH_ZERO && c <= CH_NINE);
		d = dig ? WORD_W'(c - CH_ZERO) : '0;
		if (minus_held) begin
			minus_held = 1'b0;
			if (dig) begin
				num_active = 1'b1;
				num_neg = 1'b1;
				num_acc = d;
				return;
			end
			apply_op(OP_SUB);
		end
		if (dig) begin
			if (num_active) begin
				num_acc = num_acc * WORD_W'(10) + d;
			end else begin
				num_active = 1'b1;
				num_neg = 1'b0;
				num_acc = d;
			end
			return;
		end
		close_number();
		case (c)
			CH_PLUS:  apply_op(OP_ADD);
			CH_STAR:  apply_op(OP_MUL);
			CH_SLASH: apply_op(OP_DIV);
			CH_MINUS: minus_held = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic bit eval_char(input logic [SYM_W-1:0] c, input bit last,
			output result_t r);
		logic [WORD_W-1:0] top;
		r = '0;
		take_char(c);
		if (!last)
			return 1'b0;
		close_number();
		if (minus_held) begin
			minus_held = 1'b0;
			apply_op(OP_SUB);
		end
		top = stk_pop();
		r.value = div0_seen ? '0 : top;
		r.dz = div0_seen;
		clear_eval();
		return 1'b1;
	endfunction

	function automatic void add_sym(input logic [SYM_W-1:0] c);
		stim_q.push_back('{c, 1'b0, 1'b0, '0, 1'b0});
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_sym(s[i]);
	endfunction

	function automatic logic [SYM_W-1:0] pick_sep();
		logic [SYM_W-1:0] c;
		if ($urandom_range(0, 3) != 0)
			return " ";
		do
			c = SYM_W'($urandom_range(0, 255));
		while ((c >= CH_ZERO && c <= CH_NINE) || c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH});
		return c;
	endfunction

	function automatic void add_number(input bit deep);
		longint unsigned mag;
		int k;
		if ($urandom_range(0, 3) == 0)
			add_sym(CH_MINUS);
		k = $urandom_range(0, 19);
		if (deep)
			mag = $urandom_range(0, 9);
		else if (k < 12)
			mag = $urandom_range(0, 20);
		else if (k < 15)
			mag = $urandom_range(0, 99999);
		else if (k < 17)
			mag = $urandom;
		else if (k == 17)
			mag = 64'd2147483647 + $urandom_range(0, 1);
		else if (k == 18)
			mag = 64'd4294967295;
		else begin
			// digit run long enough to wrap
			repeat ($urandom_range(11, 16))
				add_sym(CH_ZERO + SYM_W'($urandom_range(0, 9)));
			return;
		end
		add_text($sformatf("%0d", mag));
	endfunction

	function automatic void build_expr(input bit deep);
		int depth, pushed, operands, mode;
		bit need_sep;
		logic [SYM_W-1:0] c;
		mode = $urandom_range(0, 19);
		if (!deep && mode < 2) begin
			repeat ($urandom_range(1, 8))
				add_sym(SYM_W'($urandom_range(0, 255)));
		end else if (!deep && mode == 2) begin
			add_text("-2147483648 -1/");
		end else begin
			operands = deep ? $urandom_range(62, 70) : $urandom_range(1, 6);
			depth = 0;
			pushed = 0;
			need_sep = 1'b0;
			while (pushed < operands || depth > 1) begin
				if (pushed < operands && (deep || depth < 2 || $urandom_range(0, 2) == 0)) begin
					if (need_sep)
						add_sym(pick_sep());
					add_number(deep);
					pushed++;
					depth++;
					need_sep = 1'b1;
				end else begin
					// a '-' operator needs a separator before a following number
					c = OP_CHARS[$urandom_range(0, 3)];
					add_sym(c);
					depth--;
					need_sep = (c == CH_MINUS);
				end
				if ($urandom_range(0, 29) == 0)
					add_sym(SYM_W'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 9) == 0)
				add_sym(pick_sep());
		end
		stim_q[stim_q.size()-1].last = 1'b1;
	endfunction

	task automatic send_item(input sym_item_t item);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= item.sym;
		s_tlast <= item.last;
		drv_typed <= item.typed;
		drv_tval <= item.tval;
		drv_tdz <= item.tdz;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (exp_results.size() != 0);
	endtask

	// output side: random stalls plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		result_t pred, want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (eval_char(s_tdata, s_tlast, pred))
					exp_results.push_back(drv_typed ? result_t'({drv_tval, drv_tdz}) : pred);
			end
			if (m_tvalid && m_tready) begin
				if (exp_results.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result: value %0d divide_by_zero %0b",
							$signed(m_tdata), m_tuser);
					mismatches++;
				end else begin
					want = exp_results.pop_front();
					if (m_tdata !== want.value || m_tuser !== want.dz) begin
						if (mismatches < 10)
							$display("mismatch: expected %0d/%0b, got %0d/%0b",
								$signed(want.value), want.dz, $signed(m_tdata), m_tuser);
						mismatches++;
					end
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_rpn_stack_evaluator: errors");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		bit first;
		sym_item_t item;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_item(DIRECTED_ROWS[i]);

		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			src_idle_pct = (phase == 1) ? 49 : (phase == 3) ? 27 : 0;
			sink_stall_pct = (phase == 2) ? 49 : (phase == 3) ? 27 : 0;
			if (phase == 0)
				hold_req = 1'b1;
			sent = 0;
			first = 1'b1;
			while (sent < PHASE_ITEMS) begin
				build_expr(first && (phase % 2 == 1));
				first = 1'b0;
				while (stim_q.size() != 0) begin
					item = stim_q.pop_front();
					send_item(item);
					if (item.last || (item.sym >= CH_ZERO && item.sym <= CH_NINE) ||
							item.sym inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH})
						sent++;
				end
			end
		end

		sink_stall_pct = 0;
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("tb_rpn_stack_evaluator: clean");
		else
			$display("tb_rpn_stack_evaluator: errors");
		$finish;
	end

endmodule
